@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the semaphore table.
// Needs a signal named clk in the scope of each use, and rst for KST_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define KST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define KST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ rtl/kst_pkg.sv @@
// Package for the keyed semaphore table: field widths, request and status codes.
// No dependencies.
package kst_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;

  localparam int REQ_W  = 3;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int RET_W  = 33;

  localparam logic [REQ_W-1:0] REQ_GET    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_UPDOWN = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  localparam logic [VAL_W-1:0] CNT_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] CNT_MAX = 32'h7FFF_FFFF;

endpackage

@@ rtl/kst_req_if.sv @@
// Request channel of the keyed semaphore table: valid/ready plus request word.
// Depends on kst_pkg.
interface kst_req_if import kst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic        [REQ_W-1:0] req_type;
  logic        [KEY_W-1:0] key_or_id;
  logic signed [VAL_W-1:0] set_value;
  logic                    down_request;

  modport source (output valid, req_type, key_or_id, set_value, down_request,
                  input ready);
  modport sink   (input valid, req_type, key_or_id, set_value, down_request,
                  output ready);
endinterface

@@ rtl/kst_rsp_if.sv @@
// Response channel of the keyed semaphore table: valid/ready plus result word.
// Depends on kst_pkg.
interface kst_rsp_if import kst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [STAT_W-1:0] status;
  logic signed [RET_W-1:0]  ret_value;
  logic                     must_block;
  logic                     wake_waiter;

  modport source (output valid, status, ret_value, must_block, wake_waiter,
                  input ready);
  modport sink   (input valid, status, ret_value, must_block, wake_waiter,
                  output ready);
endinterface

@@ rtl/keyed_semaphore_table.sv @@
// Keyed semaphore table, top level: sequencer, key/counter memories, result register.
// Depends on kst_pkg, kst_req_if, kst_rsp_if and assert_macros.svh.
//
// A request word is taken only when the table is idle. The key search reads
// one entry per cycle from the key memory through its single registered read
// port and compares the key that it returns, then the ACT step reads the
// counter (or the last entry for a remove) and the EXEC step updates the
// memories and loads the result register. The result word waits in that
// register while the next request is taken; a finished request holds in its
// last step until the register is free. Keys and counters need no clearing
// after reset.
module keyed_semaphore_table import kst_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  kst_req_if.sink   req,
  kst_rsp_if.source rsp
);

  `include "assert_macros.svh"

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_ACT  = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] cnt_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] cnt_rd;

  logic [CNT_W-1:0] entry_count, count_next;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] last_cnt;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_vld;
  logic             found;
  logic [IDX_W-1:0] slot;

  logic [REQ_W-1:0] r_type;
  logic [KEY_W-1:0] r_key;
  logic [VAL_W-1:0] r_val;
  logic             r_down;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_key_en, wr_cnt_en;
  logic [KEY_W-1:0] wr_key;
  logic [VAL_W-1:0] wr_cnt;

  logic issue, hit, miss, fire;
  logic [VAL_W-1:0] cnt_upd;

  logic [STAT_W-1:0] res_status;
  logic [RET_W-1:0]  res_ret;
  logic              res_block, res_wake;

  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [RET_W-1:0]  out_ret;
  logic              out_block, out_wake;

  assign last_cnt = entry_count - 1'b1;
  assign last_idx = last_cnt[IDX_W-1:0];

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.ret_value   = out_ret;
  assign rsp.must_block  = out_block;
  assign rsp.wake_waiter = out_wake;

  always_comb begin
    state_next = state;
    rd_addr    = scan_idx[IDX_W-1:0];
    wr_addr    = slot;
    wr_key_en  = 1'b0;
    wr_cnt_en  = 1'b0;
    wr_key     = r_key;
    wr_cnt     = '0;
    count_next = entry_count;
    issue      = 1'b0;
    hit        = 1'b0;
    miss       = 1'b0;
    fire       = 1'b0;
    cnt_upd    = cnt_rd;
    res_status = ST_OK;
    res_ret    = '0;
    res_block  = 1'b0;
    res_wake   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        issue = (scan_idx < entry_count);
        hit   = cmp_vld && (key_rd == r_key);
        miss  = !cmp_vld && !issue;
        if (hit || miss) state_next = S_ACT;
      end
      S_ACT: begin
        rd_addr    = (r_type == REQ_REMOVE) ? last_idx : slot;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // keep the read port on the same entry while the result register is busy
        rd_addr = (r_type == REQ_REMOVE) ? last_idx : slot;
        if (!out_valid || rsp.ready) begin
          fire       = 1'b1;
          state_next = S_IDLE;
          priority if (r_type == REQ_GET) begin
            if (found) begin
              res_ret = {1'b0, r_key};
            end else if (entry_count == FULL_COUNT) begin
              res_status = ST_FULL;
            end else begin
              wr_addr    = entry_count[IDX_W-1:0];
              wr_key_en  = 1'b1;
              wr_cnt_en  = 1'b1;
              count_next = entry_count + 1'b1;
              res_ret    = {1'b0, r_key};
            end
          end else if (!found || (r_type > REQ_UPDOWN)) begin
            res_status = ST_NOT_FOUND;
          end else begin
            unique case (r_type)
              REQ_READ: res_ret = {cnt_rd[VAL_W-1], cnt_rd};
              REQ_SET: begin
                wr_cnt_en = 1'b1;
                wr_cnt    = r_val;
              end
              REQ_REMOVE: begin
                // last entry fills the freed slot; a no-op when slot is last
                wr_key_en  = 1'b1;
                wr_cnt_en  = 1'b1;
                wr_key     = key_rd;
                wr_cnt     = cnt_rd;
                count_next = last_cnt;
              end
              REQ_UPDOWN: begin
                if (r_down) begin
                  cnt_upd   = (cnt_rd == CNT_MIN) ? cnt_rd : cnt_rd - 1'b1;
                  res_block = cnt_upd[VAL_W-1];
                end else begin
                  cnt_upd  = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
                  res_wake = cnt_upd[VAL_W-1] || (cnt_upd == '0);
                end
                wr_cnt_en = 1'b1;
                wr_cnt    = cnt_upd;
              end
              default: res_status = ST_NOT_FOUND;
            endcase
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    key_rd <= key_mem[rd_addr];
    cnt_rd <= cnt_mem[rd_addr];
    if (wr_key_en) key_mem[wr_addr] <= wr_key;
    if (wr_cnt_en) cnt_mem[wr_addr] <= wr_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      scan_idx    <= '0;
      cmp_vld     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= count_next;
      if (state == S_IDLE) begin
        scan_idx <= '0;
        cmp_vld  <= 1'b0;
      end else if (state == S_SCAN) begin
        cmp_vld <= issue;
        if (issue) scan_idx <= scan_idx + 1'b1;
      end
      if (fire) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      r_type <= req.req_type;
      r_key  <= req.key_or_id;
      r_val  <= req.set_value;
      r_down <= req.down_request;
    end
    if (state == S_SCAN) begin
      cmp_idx <= scan_idx[IDX_W-1:0];
      if (hit) begin
        found <= 1'b1;
        slot  <= cmp_idx;
      end else if (miss) begin
        found <= 1'b0;
      end
    end
    if (fire) begin
      out_status <= res_status;
      out_ret    <= res_ret;
      out_block  <= res_block;
      out_wake   <= res_wake;
    end
  end

  `KST_ASSERT(a_count_bound, entry_count <= FULL_COUNT, "entry count above depth")
  `KST_ASSERT(a_accept_scan, (req.valid && req.ready) |=> (state == S_SCAN), "accept without search")
  `KST_ASSERT(a_count_change, (!$past(rst) && (entry_count != $past(entry_count))) |-> ($past(state) == S_EXEC), "entry count changed outside update")
  `KST_ASSERT(a_rsp_from_exec, $rose(rsp.valid) |-> ($past(state) == S_EXEC), "result word without update step")

endmodule
